### sv/ctwt_pkg.sv
// ctwt_pkg: shared constants and types for counter_to_wall_time
// no dependencies
`timescale 1ns / 1ps

package ctwt_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned NS_W   = 30;
   localparam int unsigned ADDR_W = 2;

   localparam logic [ADDR_W-1:0] REG_BOOT_COUNT    = 2'd0;
   localparam logic [ADDR_W-1:0] REG_COUNT_RATE    = 2'd1;
   localparam logic [ADDR_W-1:0] REG_EPOCH_SECONDS = 2'd2;

   localparam logic [WORD_W-1:0] RATE_RESET  = 64'd2500000000;
   localparam logic [WORD_W-1:0] NS_PER_SEC  = 64'd1000000000;

   // one partial product of the remainder times 10^9 (16 bits of the remainder)
   localparam int unsigned SLICE_W = 16;

   typedef struct packed {
      logic [WORD_W-1:0] seconds;
      logic [NS_W-1:0]   nanoseconds;
   } rsp_type;

endpackage

### sv/ctwt_stream_if.sv
// ctwt_stream_if: valid/ready channel carrying a payload
// depends on nothing; the payload type is a parameter
`timescale 1ns / 1ps

interface ctwt_stream_if #(
   parameter type payload_type = logic [63:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### sv/counter_to_wall_time.sv
// counter_to_wall_time: cycle counter sample to seconds and nanoseconds
// depends on ctwt_pkg and ctwt_stream_if
`timescale 1ns / 1ps

// channel | direction | payload
// req     | in        | now_count [63:0]
// rsp     | out       | seconds [63:0], nanoseconds [29:0]
// csr     | in        | csr_we, csr_addr [1:0], csr_wdata [63:0]
//
// one transfer per cycle while rsp is not stalled
// two restoring dividers of WORD_W one-bit stages each, one multiply phase
// of four 16x30 partial products between them
// reset is synchronous and clears only the valid bits and the csr registers
// a stall at rsp holds every stage at once; no item is dropped or repeated

module counter_to_wall_time (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [ctwt_pkg::ADDR_W-1:0] csr_addr,
   input  logic [ctwt_pkg::WORD_W-1:0] csr_wdata,
   ctwt_stream_if.sink                 req,
   ctwt_stream_if.source               rsp
);
   localparam int unsigned W  = ctwt_pkg::WORD_W;
   localparam int unsigned NQ = W;          // stages of each divider

   logic [W-1:0] boot_ff, rate_ff, epoch_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         boot_ff  <= '0;
         rate_ff  <= ctwt_pkg::RATE_RESET;
         epoch_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            ctwt_pkg::REG_BOOT_COUNT:    boot_ff  <= csr_wdata;
            ctwt_pkg::REG_COUNT_RATE:    rate_ff  <= csr_wdata;
            ctwt_pkg::REG_EPOCH_SECONDS: epoch_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance: the whole pipe moves unless the output is blocked
   logic adv;
   logic out_v_ff;
   assign adv       = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   // first divider: elapsed / rate, one quotient bit a stage
   logic         d1_v_ff [NQ+1];
   logic         d1_z_ff [NQ+1];
   logic [W-1:0] d1_r_ff [NQ+1];   // partial remainder
   logic [W-1:0] d1_q_ff [NQ+1];   // dividend shifting into quotient

   // stage 0: subtract, flag the epoch case
   always_ff @(posedge clock) begin
      if (reset) d1_v_ff[0] <= 1'b0;
      else if (adv) d1_v_ff[0] <= req.valid;
      if (adv) begin
         d1_z_ff[0] <= (rate_ff == '0) || (req.payload < boot_ff);
         d1_r_ff[0] <= '0;
         d1_q_ff[0] <= req.payload - boot_ff;
      end
   end

   for (genvar i = 0; i < NQ; i++) begin : g_div1
      logic [W:0]   rs;
      logic [W:0]   df;
      assign rs = {d1_r_ff[i], d1_q_ff[i][W-1]};
      assign df = rs - {1'b0, rate_ff};
      always_ff @(posedge clock) begin
         if (reset) d1_v_ff[i+1] <= 1'b0;
         else if (adv) d1_v_ff[i+1] <= d1_v_ff[i];
         if (adv) begin
            d1_z_ff[i+1] <= d1_z_ff[i];
            if (!df[W]) begin
               d1_r_ff[i+1] <= df[W-1:0];
               d1_q_ff[i+1] <= {d1_q_ff[i][W-2:0], 1'b1};
            end else begin
               d1_r_ff[i+1] <= rs[W-1:0];
               d1_q_ff[i+1] <= {d1_q_ff[i][W-2:0], 1'b0};
            end
         end
      end
   end

   // second divider: product / rate, the quotient rides along
   logic         d2_v_ff [NQ+1];
   logic         d2_z_ff [NQ+1];
   logic [W-1:0] d2_r_ff [NQ+1];
   logic [W-1:0] d2_n_ff [NQ+1];
   logic [W-1:0] d2_s_ff [NQ+1];   // whole seconds quotient

   // multiply phase: remainder times 10^9 mod 2^64, partial products then sum
   localparam int unsigned NP = W / ctwt_pkg::SLICE_W;
   logic         m1_v_ff, m1_z_ff;
   logic [W-1:0] m1_q_ff;
   logic [W-1:0] m1_pp_ff [NP];
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff    <= 1'b0;
         d2_v_ff[0] <= 1'b0;
      end else if (adv) begin
         m1_v_ff    <= d1_v_ff[NQ];
         d2_v_ff[0] <= m1_v_ff;
      end
      if (adv) begin
         m1_z_ff <= d1_z_ff[NQ];
         m1_q_ff <= d1_q_ff[NQ];
         for (int k = 0; k < NP; k++) begin
            m1_pp_ff[k] <= W'({{(W-ctwt_pkg::SLICE_W){1'b0}},
                     d1_r_ff[NQ][k*ctwt_pkg::SLICE_W +: ctwt_pkg::SLICE_W]}
                     * ctwt_pkg::NS_PER_SEC) << (k * ctwt_pkg::SLICE_W);
         end
         d2_z_ff[0] <= m1_z_ff;
         d2_s_ff[0] <= m1_q_ff;
         d2_r_ff[0] <= '0;
         d2_n_ff[0] <= m1_pp_ff[0] + m1_pp_ff[1] + m1_pp_ff[2] + m1_pp_ff[3];
      end
   end

   for (genvar i = 0; i < NQ; i++) begin : g_div2
      logic [W:0] rs;
      logic [W:0] df;
      assign rs = {d2_r_ff[i], d2_n_ff[i][W-1]};
      assign df = rs - {1'b0, rate_ff};
      always_ff @(posedge clock) begin
         if (reset) d2_v_ff[i+1] <= 1'b0;
         else if (adv) d2_v_ff[i+1] <= d2_v_ff[i];
         if (adv) begin
            d2_z_ff[i+1] <= d2_z_ff[i];
            d2_s_ff[i+1] <= d2_s_ff[i];
            if (!df[W]) begin
               d2_r_ff[i+1] <= df[W-1:0];
               d2_n_ff[i+1] <= {d2_n_ff[i][W-2:0], 1'b1};
            end else begin
               d2_r_ff[i+1] <= rs[W-1:0];
               d2_n_ff[i+1] <= {d2_n_ff[i][W-2:0], 1'b0};
            end
         end
      end
   end

   // output register: add epoch, apply epoch case
   ctwt_pkg::rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= d2_v_ff[NQ];
      if (adv) begin
         if (d2_z_ff[NQ]) begin
            out_ff.seconds     <= epoch_ff;
            out_ff.nanoseconds <= '0;
         end else begin
            out_ff.seconds     <= epoch_ff + d2_s_ff[NQ];
            out_ff.nanoseconds <= d2_n_ff[NQ][ctwt_pkg::NS_W-1:0];
         end
      end
   end

   assign rsp.valid   = out_v_ff;
   assign rsp.payload = out_ff;

endmodule

### sv/ctwt_checker.sv
// ctwt_checker: port-level checks for counter_to_wall_time
// depends on ctwt_pkg; bound to the top level below
`timescale 1ns / 1ps

module ctwt_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input ctwt_pkg::rsp_type       rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_ns_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.nanoseconds < 30'd1000000000)
      else $error("nanoseconds out of range");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");
endmodule

bind counter_to_wall_time ctwt_checker u_ctwt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

### tb/counter_to_wall_time_checker.sv
// counter_to_wall_time_checker: predicts wall time for each accepted counter sample
// and compares it with each transfer on the result channel; depends on ctwt_pkg
`timescale 1ns / 1ps

module counter_to_wall_time_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [ctwt_pkg::ADDR_W-1:0] csr_addr,
   input  logic [ctwt_pkg::WORD_W-1:0] csr_wdata,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [63:0]                 req_count,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  ctwt_pkg::rsp_type           rsp_payload,
   output int                          mismatches,
   output int                          pending
);
   import ctwt_pkg::*;

   logic [63:0] boot_q, rate_q, epoch_q;
   rsp_type     wall_time_q[$];

   function automatic rsp_type wall_time(input logic [63:0] sample);
      rsp_type     r;
      logic [63:0] elapsed, frac, scaled;
      if (rate_q == 64'd0 || sample < boot_q) begin
         r.seconds     = epoch_q;
         r.nanoseconds = '0;
      end else begin
         elapsed       = sample - boot_q;
         frac          = elapsed % rate_q;
         r.seconds     = epoch_q + elapsed / rate_q;
         // product wraps at 64 bits before the divide
         scaled        = frac * NS_PER_SEC;
         r.nanoseconds = NS_W'(scaled / rate_q);
      end
      return r;
   endfunction

   task automatic report(input string what);
      $display("%0t: %s", $realtime, what);
      mismatches++;
   endtask

   assign pending = wall_time_q.size();

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         boot_q     <= '0;
         rate_q     <= RATE_RESET;
         epoch_q    <= '0;
         mismatches <= 0;
         wall_time_q.delete();
      end else begin
         if (req_valid && req_ready) wall_time_q.push_back(wall_time(req_count));
         if (rsp_valid && rsp_ready) begin
            if (wall_time_q.size() == 0) report("result with no sample waiting");
            else begin
               e = wall_time_q.pop_front();
               if (rsp_payload.seconds !== e.seconds)
                  report($sformatf("seconds got %0d want %0d",
                                   rsp_payload.seconds, e.seconds));
               if (rsp_payload.nanoseconds !== e.nanoseconds)
                  report($sformatf("nanoseconds got %0d want %0d",
                                   rsp_payload.nanoseconds, e.nanoseconds));
            end
         end
         if (csr_we) begin
            case (csr_addr)
               REG_BOOT_COUNT:    boot_q  <= csr_wdata;
               REG_COUNT_RATE:    rate_q  <= csr_wdata;
               REG_EPOCH_SECONDS: epoch_q <= csr_wdata;
               default: ;
            endcase
         end
      end
   end
endmodule

### tb/counter_to_wall_time_tb.sv
// counter_to_wall_time_tb: stimulus and verdict for counter_to_wall_time
// depends on ctwt_pkg, ctwt_stream_if, the block and counter_to_wall_time_checker
`timescale 1ns / 1ps

module counter_to_wall_time_tb;
   import ctwt_pkg::*;

   localparam int LATENCY = 2 * WORD_W + 4;

   logic              clock, reset;
   logic              csr_we;
   logic [ADDR_W-1:0] csr_addr;
   logic [63:0]       csr_wdata;
   int                mismatches, pending;
   bit                long_hold;     // receiver held off for the fill-up test

   ctwt_stream_if #(.payload_type(logic [63:0])) req_ch ();
   ctwt_stream_if #(.payload_type(rsp_type))     rsp_ch ();

   counter_to_wall_time u_top (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   counter_to_wall_time_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_count(req_ch.payload),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_payload(rsp_ch.payload),
      .mismatches(mismatches), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // safety limit, far beyond the slowest correct run
   initial begin
      #40ms;
      $display("Mismatches found");
      $finish;
   end

   // receiver: random stall pattern, calm stretches, and one long hold-off
   initial begin
      int mode;
      rsp_ch.ready = 1'b0;
      mode = 0;
      forever begin
         @(posedge clock);
         if (long_hold) rsp_ch.ready <= 1'b0;
         else begin
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // one register write while the pipe is empty
   task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(input logic [63:0] boot, rate, epoch);
      write_reg(REG_BOOT_COUNT, boot);
      write_reg(REG_COUNT_RATE, rate);
      write_reg(REG_EPOCH_SECONDS, epoch);
   endtask

   // offer one sample and hold it until the transfer happens
   task automatic send_sample(input logic [63:0] sample);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= sample;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // bursts of random length with random gaps between them
   task automatic send_gapped(input logic [63:0] sample);
      if ($urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      send_sample(sample);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // sample near boot, mostly in a sane range, sometimes anywhere
   function automatic logic [63:0] pick_sample(input logic [63:0] boot);
      case ($urandom_range(0, 5))
         0:       return rand64();
         1:       return boot - $urandom_range(1, 1000);
         2:       return boot + $urandom_range(0, 1000);
         default: return boot + {$urandom_range(0, 255), $urandom()};
      endcase
   endfunction

   // rates: zero, one, small, typical, huge and all ones
   function automatic logic [63:0] pick_rate();
      case ($urandom_range(0, 7))
         0:       return 64'd0;
         1:       return 64'd1;
         2:       return $urandom_range(2, 1000);
         3:       return 64'hFFFF_FFFF_FFFF_FFFF;
         4:       return rand64();
         default: return $urandom_range(1_000_000, 32'hFFFF_FFFF);
      endcase
   endfunction

   initial begin
      logic [63:0] boot;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      long_hold    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values first: default rate, boot and epoch zero
      send_sample(64'd0);
      send_sample(64'd2_500_000_001);
      send_sample(64'hFFFF_FFFF_FFFF_FFFF);
      drain();

      // directed: zero rate, sample before boot, seconds wrap, large rate, rates of one and three
      set_config(64'd100, 64'd0, 64'd77);
      send_sample(64'd500);
      send_sample(64'd0);
      drain();
      set_config(64'd100, 64'd10, 64'hFFFF_FFFF_FFFF_FFFF);
      send_sample(64'd99);
      send_sample(64'd100);
      send_sample(64'd109);
      send_sample(64'hFFFF_FFFF_FFFF_FFFF);
      drain();
      set_config(64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5);
      send_sample(64'hFFFF_FFFF_FFFF_FFFE);
      send_sample(64'hFFFF_FFFF_FFFF_FFFF);
      send_sample(64'h8000_0000_0000_0000);
      drain();
      set_config(64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'd0);
      send_sample(64'hFFFF_FFFF_FFFF_FFFF);
      send_sample(64'hFFFF_FFFF_FFFF_FFFE);
      drain();
      set_config(64'd0, 64'd3, 64'd0);
      send_sample(64'h5555_5555_5555_5555);
      send_sample(64'hAAAA_AAAA_AAAA_AAAA);
      drain();

      // long receiver hold-off while samples keep coming, so input stalls
      set_config(64'd1000, 64'd2_500_000_000, 64'd1_700_000_000);
      fork
         begin
            long_hold = 1'b1;
            repeat (LATENCY * 3) @(posedge clock);
            long_hold = 1'b0;
         end
         repeat (LATENCY * 2) send_sample(pick_sample(64'd1000));
      join
      drain();

      // random phases, each with its own setting
      for (int phase = 0; phase < 30; phase++) begin
         boot = ($urandom_range(0, 3) == 0) ? rand64() : {32'd0, $urandom()};
         set_config(boot, pick_rate(), rand64());
         repeat (55) send_gapped(pick_sample(boot));
         drain();
      end

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

### filelist.f
sv/ctwt_pkg.sv
sv/ctwt_stream_if.sv
sv/counter_to_wall_time.sv
sv/ctwt_checker.sv
tb/counter_to_wall_time_checker.sv
tb/counter_to_wall_time_tb.sv
